@@ design/efla_pkg.sv @@
// Shared types and constants for the extent free-list block allocator.
`default_nettype none

package efla_pkg;

    // Volume geometry
    localparam int MAX_BLOCKS = 4096;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int VOL_W      = BLK_W + 1;
    localparam int MIN_VOLUME = 2;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_FORMAT = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // Result status codes carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_NOT_FMT   = 2'd3
    } status_t;

    // One extent record: size in blocks and index of the next extent
    typedef struct packed {
        logic [BLK_W-1:0] size;
        logic [BLK_W-1:0] next;
    } extent_t;

    // Request from the control logic to the record store
    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        extent_t          wdata;
        logic             re;
        logic [BLK_W-1:0] raddr;
    } store_req_t;

endpackage

`default_nettype wire

@@ design/efla_store.sv @@
// Extent record store: one write port, one registered read port.
`default_nettype none

module efla_store (
    input  wire logic                clk,
    input  wire efla_pkg::store_req_t req,
    output efla_pkg::extent_t        rd_data
);
    import efla_pkg::*;

    extent_t mem [MAX_BLOCKS];
    extent_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/extent_free_list_allocator_top.sv @@
// Top level of the extent free-list block allocator.
//
// Format, free, no-operation and refused allocate beats finish when taken.
// An allocate that hands out a block also passes through S_READ, since the head
// extent record must first be read from the registered record store before the
// shrunken record is written back at head+1. One command is worked on at a
// time. A finished result sits in the output register, and the next command is
// taken while it waits. If that command finishes before the output register is
// emptied, its result is parked and the input stalls until the output register
// frees. The record store has no clearing pass: records are meaningful only
// once formatted or freed. volume_blocks is clamped to the range 2..4096 and
// must be written only while no command is outstanding.
`default_nettype none

module extent_free_list_allocator_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration: volume_blocks
    input  wire logic                       cfg_we,
    input  wire logic [efla_pkg::VOL_W-1:0] cfg_data,
    // Command stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,  // [11:0] block_index, [15:12] zero
    input  wire logic [1:0]                 s_tuser,  // [1:0] opcode
    // Result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [23:0]                     m_tdata,  // [11:0] allocated_block, [23:12] free_count
    output logic [1:0]                      m_tuser   // [1:0] status
);
    import efla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic [BLK_W-1:0] given;
        status_t          status;
        logic [BLK_W-1:0] count;
    } result_t;

    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(MAX_BLOCKS);
    localparam logic [VOL_W-1:0] VOL_MIN   = VOL_W'(MIN_VOLUME);
    localparam logic [BLK_W-1:0] CNT_MAX   = {BLK_W{1'b1}};
    localparam logic [BLK_W-1:0] BLK_ONE   = BLK_W'(1);

    state_t           state_reg, state_next;
    logic [VOL_W-1:0] volume_reg;
    logic             formatted_reg, formatted_next;
    logic [BLK_W-1:0] head_reg, head_next;
    logic [BLK_W-1:0] free_reg, free_next;
    result_t          pend_reg, pend_next;
    result_t          out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;

    store_req_t       req;
    extent_t          rd_data;
    result_t          res;
    logic             res_valid;
    logic             out_free;
    logic [VOL_W-1:0] eff_volume;
    logic [BLK_W-1:0] blk;
    opcode_t          op;

    efla_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign blk = s_tdata[BLK_W-1:0];
    assign op  = opcode_t'(s_tuser);

    // Clamp the configured volume size
    always_comb
    begin
        if (volume_reg > VOL_RESET)
        begin
            eff_volume = VOL_RESET;
        end
        else if (volume_reg < VOL_MIN)
        begin
            eff_volume = VOL_MIN;
        end
        else
        begin
            eff_volume = volume_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Command decode, record update and result routing
    always_comb
    begin
        state_next     = state_reg;
        formatted_next = formatted_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        req            = '0;
        res_valid      = 1'b0;
        res.given      = '0;
        res.status     = ST_OK;
        res.count      = free_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_valid = 1'b1;
                    case (op)
                        OP_FORMAT:
                        begin
                            req.we         = 1'b1;
                            req.waddr      = BLK_ONE;
                            req.wdata.size = BLK_W'(eff_volume - VOL_W'(1));
                            req.wdata.next = '0;
                            head_next      = BLK_ONE;
                            free_next      = BLK_W'(eff_volume - VOL_W'(1));
                            formatted_next = 1'b1;
                        end
                        OP_ALLOC:
                        begin
                            if (!formatted_reg)
                            begin
                                res.status = ST_NOT_FMT;
                            end
                            else if (head_reg == '0)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                // Fetch the head record, finish next cycle
                                req.re     = 1'b1;
                                req.raddr  = head_reg;
                                res_valid  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        OP_FREE:
                        begin
                            if (!formatted_reg)
                            begin
                                res.status = ST_NOT_FMT;
                            end
                            else if (blk == '0 || {1'b0, blk} >= eff_volume)
                            begin
                                res.status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                // Push a one-block extent onto the list head
                                req.we         = 1'b1;
                                req.waddr      = blk;
                                req.wdata.size = BLK_ONE;
                                req.wdata.next = head_reg;
                                head_next      = blk;
                                if (free_reg != CNT_MAX)
                                begin
                                    free_next = free_reg + BLK_ONE;
                                end
                            end
                        end
                        default:
                        begin
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Shrink the head extent or step to the next one
                res_valid = 1'b1;
                res.given = head_reg;
                if (free_reg != '0)
                begin
                    free_next = free_reg - BLK_ONE;
                end
                if (rd_data.size > BLK_ONE)
                begin
                    req.we         = 1'b1;
                    req.waddr      = head_reg + BLK_ONE;
                    req.wdata.size = rd_data.size - BLK_ONE;
                    req.wdata.next = rd_data.next;
                    head_next      = head_reg + BLK_ONE;
                end
                else
                begin
                    head_next = rd_data.next;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_next      = pend_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hand the result to the output register or park it
        if (res_valid)
        begin
            res.count = free_next;
            if (out_free)
            begin
                out_next      = res;
                m_tvalid_next = 1'b1;
                state_next    = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_WAIT;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            volume_reg    <= VOL_RESET;
            formatted_reg <= 1'b0;
            head_reg      <= '0;
            free_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            formatted_reg <= formatted_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we)
            begin
                volume_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.given};
    assign m_tuser  = out_reg.status;

    // The record read state is only entered from an accepted allocate
    a_read_follows_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> $past(s_tvalid && s_tready && op == OP_ALLOC))
        else $error("record read state entered without an allocate");

    // A non-zero block is only ever handed out with a good status
    a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[BLK_W-1:0] != '0 |-> m_tuser == ST_OK)
        else $error("block returned with an error status");

    // Before format the list is empty and the count is zero
    a_unformatted_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !formatted_reg |-> head_reg == '0 && free_reg == '0)
        else $error("list state changed before format");

    // Format leaves the head at block one
    a_format_head: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && op == OP_FORMAT |=> head_reg == BLK_ONE && formatted_reg)
        else $error("format did not rebuild the list head");

    // A parked result is only held while the output register is occupied
    a_wait_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_WAIT) |-> m_tvalid)
        else $error("result parked while output was free");

endmodule

`default_nettype wire

@@ dv/extent_free_list_allocator_top_test.sv @@
// Self-checking testbench for the extent free-list block allocator top level.
`timescale 1ns / 1ps

module extent_free_list_allocator_top_test;

    import efla_pkg::*;

    // One result beat as the block should present it
    typedef struct {
        logic [BLK_W-1:0] given;
        status_t          status;
        logic [BLK_W-1:0] count;
    } alloc_result_t;

    // One row of the directed plan: a volume write or a command beat
    typedef struct packed {
        logic             is_cfg;
        logic [VOL_W-1:0] vol;
        opcode_t          op;
        logic [BLK_W-1:0] blk;
        logic             typed;
        logic [BLK_W-1:0] e_given;
        status_t          e_status;
        logic [BLK_W-1:0] e_count;
    } plan_row_t;

    localparam int PLAN_LEN = 28;
    localparam int PHASES   = 12;
    localparam int PHASE_OPS = 150;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // before any format
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b1, 12'd0, ST_NOT_FMT,   12'd0},
        '{1'b0, 13'd0,    OP_FREE,   12'd5,    1'b1, 12'd0, ST_NOT_FMT,   12'd0},
        '{1'b0, 13'd0,    OP_NOP,    12'd4095, 1'b1, 12'd0, ST_OK,        12'd0},
        // default volume, full span
        '{1'b0, 13'd0,    OP_FORMAT, 12'd4095, 1'b1, 12'd0, ST_OK,        12'd4095},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b1, 12'd1, ST_OK,        12'd4094},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b1, 12'd2, ST_OK,        12'd4093},
        '{1'b0, 13'd0,    OP_FREE,   12'd0,    1'b1, 12'd0, ST_BAD_INDEX, 12'd4093},
        '{1'b0, 13'd0,    OP_FREE,   12'd4095, 1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_FREE,   12'd2,    1'b0, 12'd0, ST_OK,        12'd0},
        // count pinned at its top
        '{1'b0, 13'd0,    OP_FREE,   12'd1,    1'b1, 12'd0, ST_OK,        12'd4095},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        // smallest volume: one usable block
        '{1'b1, 13'd2,    OP_NOP,    12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_FORMAT, 12'd0,    1'b1, 12'd0, ST_OK,        12'd1},
        '{1'b0, 13'd0,    OP_FREE,   12'd2,    1'b1, 12'd0, ST_BAD_INDEX, 12'd1},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b1, 12'd1, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b1, 12'd0, ST_FULL,      12'd0},
        // double free, then count pinned at zero
        '{1'b0, 13'd0,    OP_FREE,   12'd1,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_FREE,   12'd1,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        // volume clamped from below and from above
        '{1'b1, 13'd0,    OP_NOP,    12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_FORMAT, 12'd0,    1'b1, 12'd0, ST_OK,        12'd1},
        '{1'b1, 13'd8191, OP_NOP,    12'd0,    1'b0, 12'd0, ST_OK,        12'd0},
        '{1'b0, 13'd0,    OP_FORMAT, 12'd0,    1'b1, 12'd0, ST_OK,        12'd4095},
        '{1'b0, 13'd0,    OP_ALLOC,  12'd0,    1'b0, 12'd0, ST_OK,        12'd0}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [VOL_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;  // [11:0] block_index, [15:12] zero
    logic [1:0]           s_tuser   = OP_NOP;  // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;  // [11:0] allocated_block, [23:12] free_count
    logic [1:0]           m_tuser;  // [1:0] status

    // Allocator state as the block should hold it
    logic                 vol_fmt;
    logic [BLK_W-1:0]     vol_head;
    logic [BLK_W-1:0]     vol_free;
    logic [VOL_W-1:0]     vol_size;
    logic [BLK_W-1:0]     ext_size [MAX_BLOCKS];
    logic [BLK_W-1:0]     ext_next [MAX_BLOCKS];

    alloc_result_t        expected_results [$];
    logic [BLK_W-1:0]     held_blocks [$];
    logic [BLK_W-1:0]     last_freed;
    bit                   calm;
    int                   mismatches;

    extent_free_list_allocator_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Volume size after clamping to the usable range
    function automatic int clamped_volume();
        int v;
        v = vol_size;
        if (v > MAX_BLOCKS) v = MAX_BLOCKS;
        if (v < MIN_VOLUME) v = MIN_VOLUME;
        return v;
    endfunction

    // Apply one command to the allocator state and return its result beat
    function automatic alloc_result_t predict_command(opcode_t op, logic [BLK_W-1:0] blk);
        alloc_result_t    res;
        int               v;
        logic [BLK_W-1:0] sz;
        logic [BLK_W-1:0] nx;
        logic [BLK_W-1:0] nh;
        res.given  = '0;
        res.status = ST_OK;
        case (op)
            OP_FORMAT:
            begin
                v = clamped_volume();
                ext_size[1] = BLK_W'(v - 1);
                ext_next[1] = '0;
                vol_head    = BLK_W'(1);
                vol_free    = BLK_W'(v - 1);
                vol_fmt     = 1'b1;
            end
            OP_ALLOC:
            begin
                if (!vol_fmt)
                    res.status = ST_NOT_FMT;
                else if (vol_head == 0)
                    res.status = ST_FULL;
                else
                begin
                    sz = ext_size[vol_head];
                    nx = ext_next[vol_head];
                    res.given = vol_head;
                    if (vol_free != 0) vol_free = vol_free - 1'b1;
                    // shrink in place by moving the record up one block
                    if (sz > 1)
                    begin
                        nh = vol_head + 1'b1;
                        ext_size[nh] = sz - 1'b1;
                        ext_next[nh] = nx;
                        vol_head = nh;
                    end
                    else
                        vol_head = nx;
                end
            end
            OP_FREE:
            begin
                if (!vol_fmt)
                    res.status = ST_NOT_FMT;
                else if (blk == 0 || blk >= clamped_volume())
                    res.status = ST_BAD_INDEX;
                else
                begin
                    ext_size[blk] = BLK_W'(1);
                    ext_next[blk] = vol_head;
                    vol_head = blk;
                    if (vol_free != '1) vol_free = vol_free + 1'b1;
                end
            end
            default: ;
        endcase
        res.count = vol_free;
        return res;
    endfunction

    // Present one command beat; on acceptance, queue its expected result
    task automatic issue_command(input opcode_t op, input logic [BLK_W-1:0] blk);
        alloc_result_t res;
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, blk};
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_command(op, blk);
        expected_results.push_back(res);
        if (op == OP_FORMAT)
            held_blocks.delete();
        else if (op == OP_ALLOC && res.status == ST_OK)
            held_blocks.push_back(res.given);
        else if (op == OP_FREE && res.status == ST_OK)
            last_freed = blk;
    endtask

    // Let all results drain, allow for a trailing allocate, then write the volume
    task automatic set_volume(input logic [VOL_W-1:0] vol);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= vol;
        @(posedge clk);
        cfg_we   <= 1'b0;
        vol_size = vol;
    endtask

    // Result side: random back-pressure and field-by-field checking
    initial
    begin
        alloc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: block %0d status %0d count %0d",
                           m_tdata[11:0], m_tuser, m_tdata[23:12]);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[11:0] !== want.given)
                    begin
                        $error("allocated_block: expected %0d, got %0d", want.given, m_tdata[11:0]);
                        mismatches++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[23:12] !== want.count)
                    begin
                        $error("free_count: expected %0d, got %0d", want.count, m_tdata[23:12]);
                        mismatches++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // Stimulus: directed plan, then random phases
    initial
    begin
        int               r;
        int               k;
        logic [VOL_W-1:0] vol;
        logic [BLK_W-1:0] blk;
        vol_fmt    = 1'b0;
        vol_head   = '0;
        vol_free   = '0;
        vol_size   = VOL_W'(MAX_BLOCKS);
        last_freed = BLK_W'(1);
        calm       = 1'b0;
        mismatches = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].is_cfg)
                set_volume(PLAN[i].vol);
            else
            begin
                issue_command(PLAN[i].op, PLAN[i].blk);
                if (PLAN[i].typed)
                    expected_results[expected_results.size() - 1] =
                        '{PLAN[i].e_given, PLAN[i].e_status, PLAN[i].e_count};
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // two phases run with no idling on either side
            calm = (ph == 4 || ph == 5);
            r = $urandom_range(0, 9);
            if (r == 0)
                vol = $urandom_range(0, 1) ? VOL_W'($urandom_range(0, 1))
                                           : VOL_W'($urandom_range(4097, 8191));
            else if (r < 3)
                vol = VOL_W'($urandom_range(2, 4096));
            else
                vol = VOL_W'($urandom_range(2, 48));
            set_volume(vol);
            issue_command(OP_FORMAT, BLK_W'($urandom_range(0, 4095)));

            repeat (PHASE_OPS)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    issue_command(OP_FORMAT, BLK_W'($urandom_range(0, 4095)));
                else if (r < 8)
                    issue_command(OP_NOP, BLK_W'($urandom_range(0, 4095)));
                else if (r < 50 || (r < 88 && held_blocks.size() == 0))
                    issue_command(OP_ALLOC, BLK_W'($urandom_range(0, 4095)));
                else if (r < 88)
                begin
                    k   = $urandom_range(0, held_blocks.size() - 1);
                    blk = held_blocks[k];
                    held_blocks.delete(k);
                    issue_command(OP_FREE, blk);
                end
                else
                begin
                    // out-of-range, boundary and double frees
                    case ($urandom_range(0, 2))
                        0: blk = BLK_W'($urandom_range(0, 4095));
                        1: blk = BLK_W'(clamped_volume() - $urandom_range(0, 1));
                        default: blk = last_freed;
                    endcase
                    issue_command(OP_FREE, blk);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/efla_pkg.sv
design/efla_store.sv
design/extent_free_list_allocator_top.sv
dv/extent_free_list_allocator_top_test.sv
